### src/fbfl_pkg.sv
`default_nettype none
package fbfl_pkg;

  // Default pool depth
  localparam int POOL_DEPTH_DEF = 256;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int BLK_W    = 9;
  localparam int BCNT_W   = 9;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 8;
  localparam int USED_W   = 9;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Register reset value and used-count ceiling
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
  localparam logic [USED_W-1:0] USED_MAX        = 9'd511;

  // Controller to datapath
  typedef struct packed {
    logic accept;        // beat taken this cycle
    logic alloc_wb;      // link read back, update head
    logic sweep_step;    // write one relink entry
    logic sweep_report;  // sweep ends in a result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_req;     // beat on the inputs is a clear
    logic alloc_req;     // beat is an allocate with a free head
    logic sweep_last;    // current sweep entry is the last one
  } dp_sts_t;

endpackage
`default_nettype wire

### src/fbfl_ctrl.sv
`default_nettype none
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_sts_t  sts,
  output logic          busy,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       report;
  logic       report_next;

  // Commands decoded from state
  assign busy             = (state != ST_IDLE);
  assign cmd.accept       = start && (state == ST_IDLE);
  assign cmd.alloc_wb     = (state == ST_ALLOC);
  assign cmd.sweep_step   = (state == ST_SWEEP);
  assign cmd.sweep_report = report;

  // Next state
  always_comb begin
    state_next  = state;
    report_next = report;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (sts.clear_req) begin
            state_next  = ST_SWEEP;
            report_next = 1'b1;
          end else if (sts.alloc_req) begin
            state_next = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: state_next = ST_IDLE;
      ST_SWEEP: begin
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Reset starts a silent relink sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_SWEEP;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

endmodule
`default_nettype wire

### src/fbfl_datapath.sv
`default_nettype none
module fbfl_datapath
  import fbfl_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_cmd_t            cmd,
  output dp_sts_t                  sts,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [BLK_W-1:0]    block,
  input  wire logic                is_null,
  input  wire logic                cfg_we,
  input  wire logic [BCNT_W-1:0]   cfg_wdata,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [GRANT_W-1:0]       granted,
  output logic [USED_W-1:0]        used_count
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > BLK_W) ? CNT_W : BLK_W;

  // Link memory: {valid, next index}
  logic [IDX_W:0]      link_mem [POOL_DEPTH];
  logic [IDX_W:0]      rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [IDX_W:0]      mem_wd;

  logic [BCNT_W-1:0]   block_count;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic                head_valid;
  logic                head_valid_next;
  logic [USED_W-1:0]   used;
  logic [USED_W-1:0]   used_next;
  logic [IDX_W-1:0]    sweep_idx;

  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    act_cnt;
  logic                in_range;
  logic                last;
  logic [IDX_W-1:0]    blk_idx;

  logic                res_fire;
  logic [STATUS_W-1:0] res_status;
  logic [GRANT_W-1:0]  res_granted;

  // Effective block count, clamped to 1..POOL_DEPTH
  assign cnt_ext = CMP_W'(block_count);
  always_comb begin
    if (cnt_ext == '0) begin
      act_cnt = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(POOL_DEPTH)) begin
      act_cnt = CMP_W'(POOL_DEPTH);
    end else begin
      act_cnt = cnt_ext;
    end
  end

  assign in_range = (CMP_W'(block) < act_cnt);
  assign last     = (CMP_W'(sweep_idx) == (act_cnt - CMP_W'(1)));
  assign blk_idx  = IDX_W'(block);

  // Status to controller
  assign sts.clear_req  = (kind == KIND_CLEAR);
  assign sts.alloc_req  = (kind == KIND_ALLOC) && head_valid;
  assign sts.sweep_last = last;

  // Per-beat update of head, count, link store and result
  always_comb begin
    res_fire        = 1'b0;
    res_status      = STAT_OK;
    res_granted     = '0;
    used_next       = used;
    head_next       = head;
    head_valid_next = head_valid;
    mem_we          = 1'b0;
    mem_wa          = blk_idx;
    mem_wd          = {head_valid, head};
    if (cmd.accept) begin
      unique case (kind)
        KIND_ALLOC: begin
          // a free head goes to the read-back cycle
          if (!head_valid) begin
            res_fire   = 1'b1;
            res_status = STAT_EMPTY;
          end
        end
        KIND_FREE: begin
          res_fire = 1'b1;
          if (!is_null) begin
            if (!in_range) begin
              res_status = STAT_RANGE;
            end else begin
              mem_we          = 1'b1;
              head_next       = blk_idx;
              head_valid_next = 1'b1;
              used_next       = (used == '0) ? used : used - USED_W'(1);
            end
          end
        end
        KIND_CLEAR: begin
          res_fire = 1'b0;
        end
        default: res_fire = 1'b1;
      endcase
    end else if (cmd.alloc_wb) begin
      res_fire        = 1'b1;
      res_granted     = GRANT_W'(head);
      head_next       = rd_data[IDX_W-1:0];
      head_valid_next = rd_data[IDX_W];
      used_next       = (used == USED_MAX) ? used : used + USED_W'(1);
    end else if (cmd.sweep_step) begin
      mem_we = 1'b1;
      mem_wa = sweep_idx;
      mem_wd = {!last, IDX_W'(sweep_idx + IDX_W'(1))};
      if (last) begin
        res_fire        = cmd.sweep_report;
        head_next       = '0;
        head_valid_next = 1'b1;
        used_next       = '0;
      end
    end
  end

  // Link memory, read at the head every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_data <= link_mem[head];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      head        <= '0;
      head_valid  <= 1'b1;
      used        <= '0;
      sweep_idx   <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      head       <= head_next;
      head_valid <= head_valid_next;
      used       <= used_next;
      done       <= res_fire;
      if (cmd.accept) begin
        sweep_idx <= '0;
      end else if (cmd.sweep_step) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (res_fire) begin
      status     <= res_status;
      granted    <= res_granted;
      used_count <= used_next;
    end
  end

endmodule
`default_nettype wire

### src/fixed_block_free_list.sv
// Allocate: the accepting cycle enters ST_ALLOC, whose registered link read feeds the head
//   update and a registered result strobe; the next start is taken while that result is shown.
// Free, empty allocate, unused kind: result strobe in the cycle after accept; busy stays low.
// Clear: relink sweep of one link-memory write per block, then the result strobe.
// Reset: busy for a silent relink sweep over the effective block count; configuration still taken.
// Results cannot be stalled by the receiver: each strobe lasts one cycle.
`default_nettype none
module fixed_block_free_list
  import fbfl_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [BLK_W-1:0]    block,
  input  wire logic                is_null,
  input  wire logic                cfg_we,
  input  wire logic [BCNT_W-1:0]   cfg_wdata,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [GRANT_W-1:0]       granted,
  output logic [USED_W-1:0]        used_count
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  fbfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  fbfl_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .block      (block),
    .is_null    (is_null),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .status     (status),
    .granted    (granted),
    .used_count (used_count)
  );

  // Link read-back always ends in a result beat
  a_alloc_result : assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_wb |=> done)
    else $error("allocate read-back gave no result");

  // A free beat answers in the next cycle
  a_free_result : assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && kind == KIND_FREE) |=> done)
    else $error("free gave no result");

  // A reported clear ends with nothing handed out
  a_clear_zero : assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_step && sts.sweep_last && cmd.sweep_report) |=>
      (done && used_count == '0))
    else $error("clear result wrong");

  // Only a successful allocate carries a block index
  a_grant_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (granted == '0))
    else $error("granted set on failed beat");

endmodule
`default_nettype wire
